// File: rtl/core/rrtc_pkg.sv
// Package: shared types and constants for the round robin thread carousel.
`default_nettype none
package rrtc_pkg;
    localparam int MAX_THREADS_DEF = 64;
    localparam int SLOT_W = 6;
    localparam int TID_W  = 32;
    localparam int ACT_W  = 3;

    typedef enum logic [ACT_W-1:0] {
        ACT_SET     = 3'd0,
        ACT_SWITCH  = 3'd1,
        ACT_YIELD   = 3'd2,
        ACT_EXIT    = 3'd3,
        ACT_RESTORE = 3'd4
    } action_t;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [SLOT_W-1:0] slot;
        logic              make_runnable;
        logic [TID_W-1:0]  thread_id;
        logic [TID_W-1:0]  yield_target;
    } in_item_t;

    typedef struct packed {
        logic [SLOT_W-1:0] next_slot;
        logic              switched;
        logic              yield_hit;
        logic              ring_empty;
    } out_item_t;
endpackage
`default_nettype wire

// File: rtl/core/rrtc_if.sv
// Interfaces: valid/ready channels for items, results and configuration.
`default_nettype none
interface rrtc_in_if;
    logic               valid;
    logic               ready;
    rrtc_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rrtc_out_if;
    logic                valid;
    logic                ready;
    rrtc_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rrtc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [rrtc_pkg::SLOT_W-1:0]     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/rrtc_front.sv
// Front end: takes input transfers and queues them, two entries deep.
`default_nettype none
module rrtc_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    rrtc_in_if.sink            in_ch,
    output rrtc_pkg::in_item_t q_data,
    output logic               q_valid,
    input  wire logic          q_pop
);
    import rrtc_pkg::*;

    in_item_t   mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    logic       push;

    assign in_ch.ready = (cnt_reg != 2'd2);
    assign push        = in_ch.valid && in_ch.ready;
    assign q_valid     = (cnt_reg != 2'd0);
    assign q_data      = mem_reg[rptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= in_ch.data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (q_pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

`ifndef SYNTHESIS
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count out of range");
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |-> !in_ch.ready) else $error("ready while full");
`endif
endmodule
`default_nettype wire

// File: rtl/core/rrtc_back.sv
// Back end: ring state, sequencer that executes one action at a time.
`default_nettype none
module rrtc_back #(
    parameter int MAX_THREADS = rrtc_pkg::MAX_THREADS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire rrtc_pkg::in_item_t          q_data,
    input  wire logic                        q_valid,
    output logic                             q_pop,
    input  wire logic [rrtc_pkg::SLOT_W-1:0] idle_slot,
    rrtc_out_if.source                       out_ch
);
    import rrtc_pkg::*;

    localparam int IW = $clog2(MAX_THREADS);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b0_0000_0001,
        S_RD     = 9'b0_0000_0010,  // read links of the chosen slot
        S_UNLINK = 9'b0_0000_0100,
        S_LINK   = 9'b0_0000_1000,
        S_SRCH   = 9'b0_0001_0000,  // issue search read
        S_SCMP   = 9'b0_0010_0000,  // compare search data
        S_POP    = 9'b0_0100_0000,
        S_ADV    = 9'b0_1000_0000,  // advance head from the registered next link
        S_DONE   = 9'b1_0000_0000
    } state_t;

    // Link and id memories, registered reads
    logic [IW-1:0]    nxt_mem [MAX_THREADS];
    logic [IW-1:0]    prv_mem [MAX_THREADS];
    logic [TID_W-1:0] tid_mem [MAX_THREADS];
    logic [MAX_THREADS-1:0] run_reg;

    state_t            st_reg;
    in_item_t          it_reg;
    logic [IW-1:0]     head_reg, tgt_reg, start_reg, walk_reg;
    logic              hv_reg, hit_reg;
    logic [SLOT_W-1:0] old_reg, running_reg, truer_reg;
    logic              follow_pop_reg;   // pop after removal (exit)
    logic [IW-1:0]     rd_nxt_reg, rd_prv_reg, hp_reg;
    logic [TID_W-1:0]  rd_tid_reg;
    logic              ov_reg;
    out_item_t         ov_data_reg;

    // Memory access requests
    logic          nw_en, pw_en, tw_en;
    logic [IW-1:0] nw_a, nw_d, pw_a, pw_d, rd_a;

    // Running slot as ring index and membership
    logic          run_in_range, tr_in_range, slot_in_range;
    logic [IW-1:0] run_idx, tr_idx, slot_idx;
    assign run_in_range  = ({26'd0, running_reg} < MAX_THREADS);
    assign tr_in_range   = ({26'd0, truer_reg} < MAX_THREADS);
    assign slot_in_range = ({26'd0, it_reg.slot} < MAX_THREADS);
    assign run_idx  = IW'(running_reg);
    assign tr_idx   = IW'(truer_reg);
    assign slot_idx = IW'(it_reg.slot);

    assign q_pop        = (st_reg == S_IDLE) && q_valid && !ov_reg;
    assign out_ch.valid = ov_reg;
    assign out_ch.data  = ov_data_reg;

    // Memory write/read ports
    always_ff @(posedge clk)
    begin
        if (nw_en)
        begin
            nxt_mem[nw_a] <= nw_d;
        end
        if (pw_en)
        begin
            prv_mem[pw_a] <= pw_d;
        end
        if (tw_en)
        begin
            tid_mem[slot_idx] <= it_reg.thread_id;
        end
        rd_nxt_reg <= nxt_mem[rd_a];
        rd_prv_reg <= prv_mem[rd_a];
        rd_tid_reg <= tid_mem[rd_a];
        hp_reg     <= prv_mem[head_reg];
    end

    state_t            st_next;
    logic [IW-1:0]     head_next, tgt_next, walk_next, start_next;
    logic              hv_next, hit_next, follow_next;
    logic [SLOT_W-1:0] running_next, truer_next;
    logic [MAX_THREADS-1:0] run_next;
    logic              done;

    // Sequencer
    always_comb
    begin
        st_next      = st_reg;
        head_next    = head_reg;
        hv_next      = hv_reg;
        tgt_next     = tgt_reg;
        walk_next    = walk_reg;
        start_next   = start_reg;
        hit_next     = hit_reg;
        follow_next  = follow_pop_reg;
        running_next = running_reg;
        truer_next   = truer_reg;
        run_next     = run_reg;
        nw_en = 1'b0; nw_a = '0; nw_d = '0;
        pw_en = 1'b0; pw_a = '0; pw_d = '0;
        tw_en = 1'b0;
        rd_a  = tgt_reg;
        done  = 1'b0;
        unique case (st_reg)
            S_IDLE:
            begin
                hit_next    = 1'b0;
                follow_next = 1'b0;
                if (q_pop)
                begin
                    st_next = S_DONE;
                    unique case (q_data.action)
                        ACT_SET:
                        begin
                            tgt_next = IW'(q_data.slot);
                            st_next  = S_RD;
                        end
                        ACT_SWITCH:  st_next = S_POP;
                        ACT_YIELD:
                        begin
                            if (hv_reg && q_data.yield_target != '0)
                            begin
                                start_next = (run_in_range && run_reg[run_idx]) ?
                                             run_idx : head_reg;
                                walk_next  = start_next;
                                st_next    = S_SRCH;
                            end
                            else
                            begin
                                st_next = S_POP;
                            end
                        end
                        ACT_EXIT:
                        begin
                            follow_next = 1'b1;
                            tgt_next    = run_idx;
                            st_next     = (run_in_range && run_reg[run_idx]) ?
                                          S_RD : S_POP;
                        end
                        ACT_RESTORE:
                        begin
                            if (truer_reg != running_reg)
                            begin
                                if (tr_in_range && run_reg[tr_idx])
                                begin
                                    head_next = tr_idx;
                                    st_next   = S_POP;
                                end
                                else
                                begin
                                    running_next = truer_reg;
                                end
                            end
                        end
                        default: st_next = S_DONE;
                    endcase
                end
            end
            S_RD:
            begin
                rd_a = tgt_reg;
                if (!follow_pop_reg)
                begin
                    // set action: record id and decide link change
                    tw_en = slot_in_range;
                    if (!slot_in_range)
                    begin
                        st_next = S_DONE;
                    end
                    else if (run_reg[tgt_reg] && !it_reg.make_runnable)
                    begin
                        st_next = S_UNLINK;
                    end
                    else if (!run_reg[tgt_reg] && it_reg.make_runnable)
                    begin
                        st_next = S_LINK;
                    end
                    else
                    begin
                        st_next = S_DONE;
                    end
                end
                else
                begin
                    st_next = S_UNLINK;
                end
            end
            S_UNLINK:
            begin
                // rd_*_reg hold links of tgt
                if (hv_reg && head_reg == tgt_reg)
                begin
                    head_next = rd_nxt_reg;
                    if (rd_nxt_reg == tgt_reg)
                    begin
                        hv_next   = 1'b0;
                        head_next = '0;
                    end
                end
                nw_en = 1'b1; nw_a = rd_prv_reg; nw_d = rd_nxt_reg;
                pw_en = 1'b1; pw_a = rd_nxt_reg; pw_d = rd_prv_reg;
                run_next[tgt_reg] = 1'b0;
                st_next = follow_pop_reg ? S_POP : S_DONE;
            end
            S_LINK:
            begin
                // hp_reg holds prev of head
                run_next[tgt_reg] = 1'b1;
                if (!hv_reg)
                begin
                    head_next = tgt_reg;
                    hv_next   = 1'b1;
                    nw_en = 1'b1; nw_a = tgt_reg; nw_d = tgt_reg;
                    pw_en = 1'b1; pw_a = tgt_reg; pw_d = tgt_reg;
                    st_next = S_DONE;
                end
                else
                begin
                    // first tgt's own links, then the neighbors in S_POP
                    nw_en = 1'b1; nw_a = tgt_reg;  nw_d = head_reg;
                    pw_en = 1'b1; pw_a = tgt_reg;  pw_d = hp_reg;
                    st_next = S_POP;
                    follow_next = 1'b0;
                    walk_next = hp_reg;
                    hit_next  = 1'b1; // marks link fix-up phase
                end
            end
            S_SRCH:
            begin
                rd_a    = walk_reg;
                st_next = S_SCMP;
            end
            S_SCMP:
            begin
                if (rd_tid_reg == it_reg.yield_target)
                begin
                    running_next = SLOT_W'(walk_reg);
                    hit_next     = 1'b1;
                    st_next      = S_DONE;
                end
                else if (rd_nxt_reg == start_reg)
                begin
                    st_next = S_POP;
                end
                else
                begin
                    walk_next = rd_nxt_reg;
                    st_next   = S_SRCH;
                end
            end
            S_POP:
            begin
                if (it_reg.action == ACT_SET)
                begin
                    // link fix-up of an insert
                    nw_en = 1'b1; nw_a = walk_reg; nw_d = tgt_reg;
                    pw_en = 1'b1; pw_a = head_reg; pw_d = tgt_reg;
                    hit_next = 1'b0;
                    st_next  = S_DONE;
                end
                else
                begin
                    // run the head, fetch its next link for the advance
                    rd_a = head_reg;
                    if (hv_reg)
                    begin
                        running_next = SLOT_W'(head_reg);
                        truer_next   = SLOT_W'(head_reg);
                        st_next      = S_ADV;
                    end
                    else
                    begin
                        running_next = idle_slot;
                        truer_next   = idle_slot;
                        st_next      = S_DONE;
                    end
                end
            end
            S_ADV:
            begin
                head_next = rd_nxt_reg;
                st_next   = S_DONE;
            end
            S_DONE:
            begin
                done    = 1'b1;
                st_next = S_IDLE;
            end
            default: st_next = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= S_IDLE;
            head_reg       <= '0;
            hv_reg         <= 1'b0;
            running_reg    <= '0;
            truer_reg      <= '0;
            run_reg        <= '0;
            hit_reg        <= 1'b0;
            follow_pop_reg <= 1'b0;
            ov_reg         <= 1'b0;
        end
        else
        begin
            st_reg         <= st_next;
            head_reg       <= head_next;
            hv_reg         <= hv_next;
            running_reg    <= running_next;
            truer_reg      <= truer_next;
            run_reg        <= run_next;
            hit_reg        <= hit_next;
            follow_pop_reg <= follow_next;
            if (done)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        tgt_reg   <= tgt_next;
        walk_reg  <= walk_next;
        start_reg <= start_next;
        if (q_pop)
        begin
            it_reg  <= q_data;
            old_reg <= running_reg;
        end
        if (done)
        begin
            ov_data_reg.next_slot  <= running_reg;
            ov_data_reg.switched   <= (running_reg != old_reg);
            ov_data_reg.yield_hit  <= hit_reg && (it_reg.action == ACT_YIELD);
            ov_data_reg.ring_empty <= !hv_reg;
        end
    end

`ifndef SYNTHESIS
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(st_reg)) else $error("state not one-hot");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> st_reg == S_IDLE) else $error("pop while busy");
    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        (run_reg == '0 && st_reg == S_IDLE) |-> !hv_reg) else $error("head valid on empty");
`endif
endmodule
`default_nettype wire

// File: rtl/core/round_robin_thread_carousel.sv
// Top level of the round robin thread carousel.
// Each action runs through the sequencer states; a yield search walks the ring
// through registered link reads, one member at a time.
// Throughput: one item at a time, the next starts after the result transfer;
// the two-entry queue keeps accepting input transfers meanwhile.
// Reset: asynchronous, ring empty, running slot 0, idle slot 0.
`default_nettype none
module round_robin_thread_carousel #(
    parameter int MAX_THREADS = rrtc_pkg::MAX_THREADS_DEF
) (
    input wire logic   clk,
    input wire logic   rst_n,
    rrtc_in_if.sink    in_ch,
    rrtc_out_if.source out_ch,
    rrtc_cfg_if.sink   cfg
);
    import rrtc_pkg::*;

    in_item_t          q_data;
    logic              q_valid, q_pop;
    logic [SLOT_W-1:0] idle_reg;

    assign cfg.ready = 1'b1;

    // Idle slot register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_reg <= '0;
        end
        else if (cfg.valid)
        begin
            idle_reg <= cfg.data;
        end
    end

    rrtc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_data  (q_data),
        .q_valid (q_valid),
        .q_pop   (q_pop)
    );

    rrtc_back #(.MAX_THREADS(MAX_THREADS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_data    (q_data),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .idle_slot (idle_reg),
        .out_ch    (out_ch)
    );
endmodule
`default_nettype wire
